FILE: hw/rtl/shuffled_combined_lcg_uniform_macros.svh
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform generator: assertion macros
// Short forms for the concurrent checks of the generator, all clocked on
// clk_i and switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_COMBINED_LCG_UNIFORM_MACROS_SVH
`define SHUFFLED_COMBINED_LCG_UNIFORM_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define SCLU_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define SCLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sclu_pkg.sv
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform generator: package
// Generator constants, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sclu_pkg;

  // Widths of the transaction fields.
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned FRAC_SHIFT = VAL_W - FRAC_W;

  // Moduli sit just below 2^31, so 2^31 folds back as a small gap.
  localparam logic [VAL_W-1:0] MOD1 = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD2 = 31'd2147483399;
  localparam longint unsigned GAP1_L = (64'd1 << VAL_W) - 64'(MOD1);
  localparam longint unsigned GAP2_L = (64'd1 << VAL_W) - 64'(MOD2);
  localparam logic [7:0] GAP1 = 8'(GAP1_L);
  localparam logic [7:0] GAP2 = 8'(GAP2_L);

  // Multipliers of the two generators.
  localparam int unsigned MUL_W = 16;
  localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
  localparam logic [MUL_W-1:0] MUL2 = 16'd40692;
  localparam int unsigned PROD_W = VAL_W + MUL_W;

  // Output range and saturation.
  localparam logic [VAL_W-1:0]  FOLD_MAX  = MOD1 - 31'd1;
  localparam logic [FRAC_W-1:0] FRAC_CAP  = 24'd16777214;

  // Reset value of the second generator and warm-up length beyond the table.
  localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;
  localparam int unsigned WARM_EXTRA = 8;
  localparam int unsigned TABLE_DEPTH_DEFAULT = 32;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_FOLD,
    ST_MUL,
    ST_FOLD,
    ST_READ,
    ST_MIX,
    ST_OUT
  } sclu_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_seed;
    logic seed_mul;
    logic seed_fold;
    logic draw_mul;
    logic draw_fold;
    logic draw_read;
    logic draw_mix;
    logic out_load;
  } sclu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first_zero;
    logic warm_done;
  } sclu_sts_t;

endpackage

FILE: hw/rtl/sclu_in_if.sv
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform generator: request channel
// Carries one request transaction: the operation and the seed.
// ----------------------------------------------------------------------------
interface sclu_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [sclu_pkg::VAL_W-1:0]  seed;

  modport source (output valid, output operation, output seed, input ready);
  modport sink (input valid, input operation, input seed, output ready);
endinterface

FILE: hw/rtl/sclu_out_if.sv
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform generator: result channel
// Carries one result transaction: the raw integer and its Q0.24 fraction.
// ----------------------------------------------------------------------------
interface sclu_out_if;
  logic                        valid;
  logic                        ready;
  logic [sclu_pkg::VAL_W-1:0]  raw_value;
  logic [sclu_pkg::FRAC_W-1:0] unit_fraction;

  modport source (output valid, output raw_value, output unit_fraction, input ready);
  modport sink (input valid, input raw_value, input unit_fraction, output ready);
endinterface

FILE: hw/rtl/sclu_ctrl.sv
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform generator: controller
// State machine that sequences the warm-up loop and the draw steps, owns the
// request ready and the result valid, and issues datapath commands.
// ----------------------------------------------------------------------------
module sclu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sclu_pkg::sclu_sts_t sts_i,
  output sclu_pkg::sclu_cmd_t cmd_o
);

  sclu_pkg::sclu_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;
  logic                  reseed;

  // The result register may be refilled once its transaction has gone.
  assign out_free = !out_valid_q || out_ready_i;

  // A reseed runs on request, or when the first generator is still at zero.
  assign reseed = in_op_i || sts_i.first_zero;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sclu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = reseed ? sclu_pkg::ST_SEED_MUL : sclu_pkg::ST_MUL;
        end
      end
      sclu_pkg::ST_SEED_MUL:  state_d = sclu_pkg::ST_SEED_FOLD;
      sclu_pkg::ST_SEED_FOLD: begin
        state_d = sts_i.warm_done ? sclu_pkg::ST_MUL : sclu_pkg::ST_SEED_MUL;
      end
      sclu_pkg::ST_MUL:  state_d = sclu_pkg::ST_FOLD;
      sclu_pkg::ST_FOLD: state_d = sclu_pkg::ST_READ;
      sclu_pkg::ST_READ: state_d = sclu_pkg::ST_MIX;
      sclu_pkg::ST_MIX:  state_d = sclu_pkg::ST_OUT;
      sclu_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = sclu_pkg::ST_IDLE;
        end
      end
      default: state_d = sclu_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sclu_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_seed = in_valid_i && reseed;
      end
      sclu_pkg::ST_SEED_MUL:  cmd_o.seed_mul  = 1'b1;
      sclu_pkg::ST_SEED_FOLD: cmd_o.seed_fold = 1'b1;
      sclu_pkg::ST_MUL:       cmd_o.draw_mul  = 1'b1;
      sclu_pkg::ST_FOLD:      cmd_o.draw_fold = 1'b1;
      sclu_pkg::ST_READ:      cmd_o.draw_read = 1'b1;
      sclu_pkg::ST_MIX:       cmd_o.draw_mix  = 1'b1;
      sclu_pkg::ST_OUT:       cmd_o.out_load  = out_free;
      default: cmd_o = '0;
    endcase
  end

  // Result valid is set on load and cleared when the transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sclu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/sclu_datapath.sv
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform generator: datapath
// Generator registers, one multiply stage and one modular fold stage for each
// generator, the shuffle table memory, table index and fraction arithmetic,
// and the result register.
// ----------------------------------------------------------------------------
module sclu_datapath #(
  parameter int unsigned TABLE_DEPTH = sclu_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sclu_pkg::sclu_cmd_t         cmd_i,
  output sclu_pkg::sclu_sts_t         sts_o,
  input  logic                        op_i,
  input  logic [sclu_pkg::VAL_W-1:0]  seed_i,
  output logic [sclu_pkg::VAL_W-1:0]  raw_value_o,
  output logic [sclu_pkg::FRAC_W-1:0] unit_fraction_o
);

  localparam int unsigned VW    = sclu_pkg::VAL_W;
  localparam int unsigned FW    = sclu_pkg::FRAC_W;
  localparam int unsigned PW    = sclu_pkg::PROD_W;
  localparam int unsigned IDXW  = $clog2(TABLE_DEPTH);
  localparam int unsigned WARM  = TABLE_DEPTH + sclu_pkg::WARM_EXTRA;
  localparam int unsigned CNTW  = $clog2(WARM);
  // Bucket width of the index and its reciprocal scaled by 2^31.
  localparam longint unsigned BUCKET = 1 + (64'(sclu_pkg::FOLD_MAX) / TABLE_DEPTH);
  localparam longint unsigned RECIP  = (64'd1 << VW) / BUCKET;
  localparam int unsigned RW    = $clog2(RECIP + 1);
  localparam int unsigned EW    = VW + RW;
  localparam logic [VW:0]       BUCKET_V = (VW + 1)'(BUCKET);
  localparam logic [RW-1:0]     RECIP_V  = RW'(RECIP);
  localparam logic [IDXW:0]     IDX_LAST = (IDXW + 1)'(TABLE_DEPTH - 1);

  // x * mul mod m for m = 2^31 - gap: the high part folds back times gap,
  // leaving a value below 2m that one subtraction brings into range.
  function automatic logic [VW-1:0] mod_fold(input logic [PW-1:0] p,
                                             input logic [7:0]    gap,
                                             input logic [VW-1:0] m);
    logic [VW:0] s;
    s = {1'b0, p[VW-1:0]} + ((VW + 1)'(p[PW-1:VW]) * (VW + 1)'(gap));
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[VW-1:0];
  endfunction

  logic [VW-1:0]   first_q, second_q, last_q;
  logic [PW-1:0]   prod1_q, prod2_q;
  logic [CNTW-1:0] cnt_q;
  logic [IDXW-1:0] est_q, idx_q;
  logic [VW-1:0]   rd_q;
  logic [VW-1:0]   raw_q;
  logic [FW-1:0]   frac_q;

  logic [VW-1:0]   seed_init;
  logic [VW-1:0]   fold1, fold2;
  logic [EW-1:0]   est_prod;
  logic [VW:0]     est_bound;
  logic [IDXW:0]   idx_fix;
  logic [IDXW-1:0] idx_d;
  logic [VW:0]     diff;
  logic [VW-1:0]   last_d;
  logic [FW-1:0]   frac_est;
  logic [VW:0]     frac_rem;
  logic [FW:0]     frac_sum;
  logic [FW-1:0]   frac_d;

  logic [VW-1:0]   tbl_mem [TABLE_DEPTH];
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  logic [VW-1:0]   wr_data;

  // Seed selection: a draw without request reseeds from one, zero means one.
  assign seed_init = (op_i && (seed_i != '0)) ? seed_i : VW'(1);

  assign fold1 = mod_fold(prod1_q, sclu_pkg::GAP1, sclu_pkg::MOD1);
  assign fold2 = mod_fold(prod2_q, sclu_pkg::GAP2, sclu_pkg::MOD2);

  assign sts_o.first_zero = (first_q == '0);
  assign sts_o.warm_done  = (cnt_q == '0);

  // Table index: reciprocal estimate is exact or one low, one check fixes it.
  assign est_prod  = EW'(last_q) * EW'(RECIP_V);
  assign est_bound = ((VW + 1)'(est_q) * BUCKET_V) + BUCKET_V;
  always_comb begin
    idx_fix = {1'b0, est_q};
    if ({1'b0, last_q} >= est_bound) begin
      idx_fix = idx_fix + (IDXW + 1)'(1);
    end
    if (idx_fix > IDX_LAST) begin
      idx_fix = IDX_LAST;
    end
  end
  assign idx_d = idx_fix[IDXW-1:0];

  // Shuffled output: table entry minus second generator, folded above zero.
  always_comb begin
    diff = {1'b0, rd_q} - {1'b0, second_q};
    if ($signed(diff) < $signed((VW + 1)'(1))) begin
      diff = diff + {1'b0, sclu_pkg::FOLD_MAX};
    end
  end
  assign last_d = diff[VW-1:0];

  // Fraction floor(last * 2^24 / MOD1): last >> 7 is exact or one low.
  assign frac_est = last_q[VW-1:sclu_pkg::FRAC_SHIFT];
  assign frac_rem = (VW + 1)'({last_q[sclu_pkg::FRAC_SHIFT-1:0], {FW{1'b0}}})
                  + ((VW + 1)'(frac_est) * (VW + 1)'(sclu_pkg::GAP1));
  always_comb begin
    frac_sum = {1'b0, frac_est};
    if (frac_rem >= {1'b0, sclu_pkg::MOD1}) begin
      frac_sum = frac_sum + (FW + 1)'(1);
    end
    frac_d = (frac_sum > {1'b0, sclu_pkg::FRAC_CAP}) ? sclu_pkg::FRAC_CAP
                                                     : frac_sum[FW-1:0];
  end

  // Generator state and last output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= sclu_pkg::SECOND_RESET;
      last_q   <= '0;
    end else begin
      if (cmd_i.load_seed) begin
        first_q  <= seed_init;
        second_q <= seed_init;
      end
      if (cmd_i.seed_fold) begin
        first_q <= fold1;
        if (cnt_q == '0) begin
          last_q <= fold1;
        end
      end
      if (cmd_i.draw_fold) begin
        first_q  <= fold1;
        second_q <= fold2;
      end
      if (cmd_i.draw_mix) begin
        last_q <= last_d;
      end
    end
  end

  // Multiply stage, warm-up counter, table index pipeline and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seed) begin
      cnt_q <= CNTW'(WARM - 1);
    end
    if (cmd_i.seed_mul || cmd_i.draw_mul) begin
      prod1_q <= PW'(first_q) * PW'(sclu_pkg::MUL1);
    end
    if (cmd_i.draw_mul) begin
      prod2_q <= PW'(second_q) * PW'(sclu_pkg::MUL2);
      est_q   <= est_prod[VW +: IDXW];
    end
    if (cmd_i.seed_fold) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
    if (cmd_i.draw_fold) begin
      idx_q <= idx_d;
    end
    if (cmd_i.out_load) begin
      raw_q  <= last_q;
      frac_q <= frac_d;
    end
  end

  // Shuffle table port: warm-up fills from the top entry down, a draw
  // refills the entry that it used.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = first_q;
    if (cmd_i.seed_fold && (cnt_q < CNTW'(TABLE_DEPTH))) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[IDXW-1:0];
      wr_data = fold1;
    end else if (cmd_i.draw_mix) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_read) begin
      rd_q <= tbl_mem[idx_q];
    end
  end

  assign raw_value_o     = raw_q;
  assign unit_fraction_o = frac_q;

endmodule

FILE: hw/rtl/shuffled_combined_lcg_uniform.sv
// ----------------------------------------------------------------------------
// Shuffled combined LCG uniform generator: top level
// Combined multiplicative congruential generator with a Bays-Durham shuffle
// table, giving a raw integer and a Q0.24 fraction per request.
// ----------------------------------------------------------------------------
// One request gives one result. A draw runs from the accepting edge to a
// valid result through one multiply stage, one modular fold stage, one
// registered table read, the output mix and the fraction stage, run in turn
// by the controller. The controller returns to its idle state at the edge
// that loads the result. A reseed (requested, or forced by the first draw
// after reset) first runs the warm-up loop of the first generator, a multiply
// and a fold per step for TABLE_DEPTH + 8 steps, 40 steps at the default
// depth of 32. A result that waits in the output register holds the
// controller until the register is free. The next request is taken as soon
// as the controller is back in its idle state, while the previous result may
// still wait in the output register. The shuffle table is a memory without
// reset; every path after reset reseeds and fills it before it is read, so no
// clearing pass is needed.
`include "shuffled_combined_lcg_uniform_macros.svh"

module shuffled_combined_lcg_uniform #(
  parameter int unsigned TABLE_DEPTH = sclu_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sclu_in_if.sink           req_i,
  sclu_out_if.source        rsp_o
);

  sclu_pkg::sclu_cmd_t cmd;
  sclu_pkg::sclu_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  // Sequencing.
  sclu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.operation),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  sclu_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (req_i.operation),
    .seed_i          (req_i.seed),
    .raw_value_o     (rsp_o.raw_value),
    .unit_fraction_o (rsp_o.unit_fraction)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

  // Checks on the result range, on request pacing and on result overwrite.
  `SCLU_ASSERT_IMPLIES(a_raw_range, rsp_o.valid, (rsp_o.raw_value != '0) && (rsp_o.raw_value <= sclu_pkg::FOLD_MAX), "raw value outside its range")
  `SCLU_ASSERT_IMPLIES(a_frac_cap, rsp_o.valid, rsp_o.unit_fraction <= sclu_pkg::FRAC_CAP, "fraction above its cap")
  `SCLU_ASSERT_NEXT(a_one_at_a_time, req_i.valid && req_i.ready, !req_i.ready, "request taken while busy")
  `SCLU_ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !rsp_o.valid || rsp_o.ready, "pending result overwritten")

endmodule
